// ----- src/bise_pkg.sv -----
// shared types, command codes and sizes for the bounded integer set engine
`timescale 1ns / 1ps
package bise_pkg;

	// default number of cells in each set chain
	localparam int SET_DEPTH_DEF = 16;
	// longest result run, and a counter wide enough to hold it
	localparam int MAX_OUT = 32;
	localparam int EMIT_W = $clog2(MAX_OUT + 1);
	// capacity register width
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// command codes
	localparam logic [3:0] CMD_ADD_A     = 4'd0;
	localparam logic [3:0] CMD_ADD_B     = 4'd1;
	localparam logic [3:0] CMD_CLEAR     = 4'd2;
	localparam logic [3:0] CMD_LIST_A    = 4'd3;
	localparam logic [3:0] CMD_LIST_B    = 4'd4;
	localparam logic [3:0] CMD_AND       = 4'd5;
	localparam logic [3:0] CMD_OR        = 4'd6;
	localparam logic [3:0] CMD_A_MINUS_B = 4'd7;
	localparam logic [3:0] CMD_B_MINUS_A = 4'd8;

	// request payload
	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] value;
	} cmd_t;

	// result payload
	typedef struct packed {
		logic signed [31:0] member;
		logic               is_empty;
		logic               last;
	} res_t;

	// per-cell load selects, at most one set in a cycle
	typedef struct packed {
		logic take_new;
		logic take_prev;
		logic take_next;
		logic take_head;
	} cell_ctl_t;

	// chain operations from the sequencer
	typedef struct packed {
		logic clear;
		logic insert;
		logic rotate;
	} chain_ctl_t;

endpackage

// ----- src/bise_cell.sv -----
// one storage cell of a sorted set chain, with its compare against the new value
`timescale 1ns / 1ps
module bise_cell (
	input  logic                clk,
	input  bise_pkg::cell_ctl_t ctl,
	input  logic signed [31:0]  new_val,
	input  logic signed [31:0]  prev_val,
	input  logic signed [31:0]  next_val,
	input  logic signed [31:0]  head_val,
	output logic signed [31:0]  val,
	output logic                gt,
	output logic                eq
);
	import bise_pkg::*;

	logic signed [31:0] val_q;

	// load from new value, left neighbour, right neighbour or chain head
	always_ff @(posedge clk) begin
		if (ctl.take_new) begin
			val_q <= new_val;
		end else if (ctl.take_prev) begin
			val_q <= prev_val;
		end else if (ctl.take_next) begin
			val_q <= next_val;
		end else if (ctl.take_head) begin
			val_q <= head_val;
		end
	end

	// local compares used for ordered insert and duplicate check
	assign val = val_q;
	assign gt  = val_q > new_val;
	assign eq  = val_q == new_val;

endmodule

// ----- src/bise_chain.sv -----
// one set held as a row of cells kept in ascending signed order
`timescale 1ns / 1ps
module bise_chain #(
	parameter int SET_DEPTH = bise_pkg::SET_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bise_pkg::chain_ctl_t             ctl,
	input  logic signed [31:0]               value,
	input  logic [bise_pkg::CAP_W-1:0]       cap,
	output logic signed [31:0]               head,
	output logic [$clog2(SET_DEPTH+1)-1:0]   count
);
	import bise_pkg::*;

	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [CW-1:0]      count_q;
	logic signed [31:0] cell_val [SET_DEPTH];
	logic [SET_DEPTH-1:0] gt, eq, below, ins;
	cell_ctl_t          cctl [SET_DEPTH];
	logic               dup, room, do_ins;

	// occupancy and insert position per cell
	for (genvar i = 0; i < SET_DEPTH; i++) begin : g_pos
		assign below[i] = CW'(i) < count_q;
		assign ins[i]   = below[i] ? gt[i] : (CW'(i) == count_q);
	end

	// insert only when absent and below both the capacity limit and the chain depth
	assign dup    = |(eq & below);
	assign room   = (CMPW'(count_q) < CMPW'(cap)) && (count_q != CW'(SET_DEPTH));
	assign do_ins = ctl.insert && !dup && room;

	// the row of cells
	for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
		logic signed [31:0] prev_v, next_v;
		if (i == 0) begin : g_first
			assign prev_v            = value;
			assign cctl[i].take_new  = do_ins && ins[i];
			assign cctl[i].take_prev = 1'b0;
		end else begin : g_rest
			assign prev_v            = cell_val[i-1];
			assign cctl[i].take_new  = do_ins && ins[i] && !ins[i-1];
			assign cctl[i].take_prev = do_ins && ins[i] && ins[i-1];
		end
		if (i == SET_DEPTH - 1) begin : g_tail
			assign next_v = cell_val[i];
		end else begin : g_mid
			assign next_v = cell_val[i+1];
		end
		assign cctl[i].take_next = ctl.rotate && (CW'(i + 1) < count_q);
		assign cctl[i].take_head = ctl.rotate && (CW'(i + 1) == count_q);

		bise_cell u_cell (
			.clk      (clk),
			.ctl      (cctl[i]),
			.new_val  (value),
			.prev_val (prev_v),
			.next_val (next_v),
			.head_val (cell_val[0]),
			.val      (cell_val[i]),
			.gt       (gt[i]),
			.eq       (eq[i])
		);
	end

	// member count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign head  = cell_val[0];
	assign count = count_q;

endmodule

// ----- src/bounded_integer_set_engine_unit.sv -----
// top level: request decode, merge sequencer, result register and register port
`timescale 1ns / 1ps
// Bounded integer set engine.
// Requests arrive on cmd_valid/cmd_stall/cmd_data and are taken when valid is
// high and stall is low. Results leave on res_valid/res_stall/res_data.
// Each set is a chain of cells kept in ascending signed order. An add or a
// clear gives no result. A list or set operation walks both chains in a
// merge, consuming members by rotating the chain heads until both chains
// are used up, and then closes the run.
// The merge is the rate limit: one request is worked on at a time and
// cmd_stall stays high until its last result is in the output register.
// Output is held one item behind so the final item can carry last; an empty
// result gives one item with is_empty and last set.
// When res_stall holds an item in the output register the merge pauses with its state intact.
// Reset empties both sets, clears the output and sets both capacities to 16.
// Capacities are written at byte addresses 0 (set A) and 4 (set B).
module bounded_integer_set_engine_unit #(
	parameter int SET_DEPTH = bise_pkg::SET_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  bise_pkg::cmd_t       cmd_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output bise_pkg::res_t       res_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import bise_pkg::*;

	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam logic REG_CAP_A = 1'b0;
	localparam logic REG_CAP_B = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// which merge outcomes belong to the result
	typedef struct packed {
		logic a_only;
		logic b_only;
		logic both;
	} rule_t;

	state_t             state_q;
	rule_t              rule_q, rule_d;
	logic [CAP_W-1:0]   cap_a_q, cap_b_q;
	logic [CW-1:0]      ia_q, ib_q, count_a, count_b;
	logic [EMIT_W-1:0]  n_emit_q;
	logic               pend_valid_q;
	logic signed [31:0] pend_q;
	logic               out_valid_q;
	res_t               out_q, push_data;
	logic signed [31:0] head_a, head_b;
	chain_ctl_t         ctl_a, ctl_b;
	logic               accept, is_walk_cmd, out_free;
	logic               a_ok, b_ok, a_lt, ab_eq, take_a, take_b, take_both;
	logic               step, emit, keep, push_mid, push_end;
	logic signed [31:0] emit_val;
	logic               cfg_wr;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_CAP_B) ? {27'd0, cap_b_q} : {27'd0, cap_a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_a_q <= CAP_RESET;
			cap_b_q <= CAP_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CAP_A) begin
				cap_a_q <= pwdata[CAP_W-1:0];
			end else begin
				cap_b_q <= pwdata[CAP_W-1:0];
			end
		end
	end

	// request decode
	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !out_valid_q || !res_stall;

	always_comb begin
		rule_d      = '0;
		is_walk_cmd = 1'b1;
		case (cmd_data.command)
			CMD_LIST_A:    rule_d = '{a_only: 1'b1, b_only: 1'b0, both: 1'b1};
			CMD_LIST_B:    rule_d = '{a_only: 1'b0, b_only: 1'b1, both: 1'b1};
			CMD_AND:       rule_d = '{a_only: 1'b0, b_only: 1'b0, both: 1'b1};
			CMD_OR:        rule_d = '{a_only: 1'b1, b_only: 1'b1, both: 1'b1};
			CMD_A_MINUS_B: rule_d = '{a_only: 1'b1, b_only: 1'b0, both: 1'b0};
			CMD_B_MINUS_A: rule_d = '{a_only: 1'b0, b_only: 1'b1, both: 1'b0};
			default:       is_walk_cmd = 1'b0;
		endcase
	end

	// merge step over the two chain heads
	assign a_ok      = ia_q < count_a;
	assign b_ok      = ib_q < count_b;
	assign a_lt      = head_a < head_b;
	assign ab_eq     = head_a == head_b;
	assign take_both = a_ok && b_ok && ab_eq;
	assign take_a    = a_ok && (!b_ok || a_lt);
	assign take_b    = b_ok && (!a_ok || (!a_lt && !ab_eq));
	assign step      = (state_q == ST_WALK) && out_free && (a_ok || b_ok);
	assign emit      = (take_a && rule_q.a_only) || (take_b && rule_q.b_only)
		|| (take_both && rule_q.both);
	assign keep      = emit && (n_emit_q < EMIT_W'(MAX_OUT));
	assign emit_val  = take_b ? head_b : head_a;
	assign push_mid  = step && keep && pend_valid_q;
	assign push_end  = (state_q == ST_DONE) && out_free;

	// chain controls
	assign ctl_a.clear  = accept && (cmd_data.command == CMD_CLEAR);
	assign ctl_a.insert = accept && (cmd_data.command == CMD_ADD_A);
	assign ctl_a.rotate = step && (take_a || take_both);
	assign ctl_b.clear  = accept && (cmd_data.command == CMD_CLEAR);
	assign ctl_b.insert = accept && (cmd_data.command == CMD_ADD_B);
	assign ctl_b.rotate = step && (take_b || take_both);

	bise_chain #(.SET_DEPTH(SET_DEPTH)) u_chain_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_a),
		.value  (cmd_data.value),
		.cap    (cap_a_q),
		.head   (head_a),
		.count  (count_a)
	);

	bise_chain #(.SET_DEPTH(SET_DEPTH)) u_chain_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_b),
		.value  (cmd_data.value),
		.cap    (cap_b_q),
		.head   (head_b),
		.count  (count_b)
	);

	// sequencer and held-back item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rule_q       <= '0;
			ia_q         <= '0;
			ib_q         <= '0;
			n_emit_q     <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && is_walk_cmd) begin
						state_q      <= ST_WALK;
						rule_q       <= rule_d;
						ia_q         <= '0;
						ib_q         <= '0;
						n_emit_q     <= '0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (!a_ok && !b_ok) begin
						state_q <= ST_DONE;
					end else if (step) begin
						if (ctl_a.rotate) begin
							ia_q <= ia_q + CW'(1);
						end
						if (ctl_b.rotate) begin
							ib_q <= ib_q + CW'(1);
						end
						if (keep) begin
							n_emit_q     <= n_emit_q + EMIT_W'(1);
							pend_valid_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q      <= ST_IDLE;
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && keep) begin
			pend_q <= emit_val;
		end
	end

	// result register
	always_comb begin
		if (push_end && !pend_valid_q) begin
			push_data = '{member: 32'sd0, is_empty: 1'b1, last: 1'b1};
		end else begin
			push_data = '{member: pend_q, is_empty: 1'b0, last: push_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_mid || push_end) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || push_end) begin
			out_q <= push_data;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a <= CW'(SET_DEPTH)) && (count_b <= CW'(SET_DEPTH)))
		else $error("set count above depth");

	a_sets_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ($stable(count_a) && $stable(count_b)))
		else $error("set changed during a result run");

	// merge positions only mean something while a run is in progress
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |->
		((ia_q <= count_a) && (ib_q <= count_b) && (n_emit_q <= EMIT_W'(MAX_OUT))))
		else $error("merge position out of range");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.is_empty) |-> res_data.last)
		else $error("empty item without last");

endmodule
